/* hw/rtl/swsq_pkg.sv */
// Package for the sorted wake-up sleep queue: sizes, status codes and the
// request, result and queue entry types. Depends on nothing else.
`default_nettype none

package swsq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int MAX_RESULTS = 16;
    localparam int TICK_BITS   = 48;
    localparam int ADDR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    localparam logic [2:0] ST_QUEUED  = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_WOKEN   = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_SLEEP = 1'b1;

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [TICK_BITS-1:0]  tick_t;
    typedef logic [ID_BITS-1:0]    id_t;

    typedef struct packed {
        logic               req_type;
        logic [7:0]         thread_id;
        logic signed [31:0] duration;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  woken_id;
        logic [47:0] tick_now;
        logic        last;
    } rsp_t;

    typedef struct packed {
        tick_t wake_time;
        id_t   sleeper_id;
    } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/swsq_ram.sv */
// Entry memory of the sleep queue: one write port and one registered read port.
// Depends on swsq_pkg for the entry type and the queue depth.
`default_nettype none

module swsq_ram (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire swsq_pkg::addr_t  wr_addr,
    input  wire swsq_pkg::entry_t wr_data,
    input  wire swsq_pkg::addr_t  rd_addr,
    output swsq_pkg::entry_t      rd_data
);
    import swsq_pkg::*;

    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/sorted_wakeup_sleep_queue.sv */
// Top level of the sorted wake-up sleep queue: tick counter, sequencer and
// output register. Depends on swsq_pkg and instantiates swsq_ram.
//
// The request channel (req_valid, req_stall, req) carries either a timer tick
// or a sleep request. The result channel (rsp_valid, rsp_stall, rsp) returns
// one result per sleep request and one or more per tick, the final one with
// last set. The queue is a circular buffer kept in ascending wake time order.
// A sleep request walks the queue from its tail, moving one later entry up a
// slot per pass of the wake time comparator, each pass a read and a compare
// step. An ignored or refused sleep passes through the decide and result
// states; a queued sleep also walks the queue and then places its entry.
// A tick reads and compares entries from the queue head, one per pass, for
// as long as threads wake. The last result enters the output register as the
// sequencer returns to idle, and req_stall is high until then. Reset clears
// the counter and empties the queue; no clearing pass is needed.
// A stalled result holds in the output register and the sequencer waits.
`default_nettype none

module sorted_wakeup_sleep_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire swsq_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output swsq_pkg::rsp_t      rsp
);
    import swsq_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECIDE    = 3'd1;
    localparam logic [2:0] S_INS_RD    = 3'd2;
    localparam logic [2:0] S_INS_CMP   = 3'd3;
    localparam logic [2:0] S_INS_PLACE = 3'd4;
    localparam logic [2:0] S_POP_RD    = 3'd5;
    localparam logic [2:0] S_POP_CMP   = 3'd6;
    localparam logic [2:0] S_RESP      = 3'd7;

    function automatic addr_t phys(addr_t head, count_t idx);
        logic [ADDR_BITS:0] s;
        s = {1'b0, head} + (ADDR_BITS + 1)'(idx);
        if (s >= (ADDR_BITS + 1)'(QUEUE_DEPTH))
        begin
            s = s - (ADDR_BITS + 1)'(QUEUE_DEPTH);
        end
        return s[ADDR_BITS-1:0];
    endfunction

    logic [2:0] state_reg, state_next;
    tick_t      tick_reg, tick_next;
    addr_t      head_reg, head_next;
    count_t     count_reg, count_next;
    count_t     slot_reg, slot_next;
    count_t     pop_n_reg, pop_n_next;
    logic       pend_valid_reg, pend_valid_next;
    id_t        pend_id_reg, pend_id_next;
    logic [2:0] resp_status_reg, resp_status_next;
    tick_t      wake_reg, wake_next;
    req_t       item_reg;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_reg, rsp_next;

    logic       accept;
    logic       out_free;
    logic       emit;
    rsp_t       emit_data;
    logic       wr_en;
    addr_t      wr_addr;
    entry_t     wr_data;
    addr_t      rd_addr;
    entry_t     rd_data;
    count_t     rd_idx;
    logic       positive;
    logic [TICK_BITS:0] wake_sum;
    logic       avail;
    logic       wakes;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign positive = !item_reg.duration[31] && (item_reg.duration != 32'sd0);
    assign wake_sum = {1'b0, tick_reg} + (TICK_BITS + 1)'(item_reg.duration[30:0]);
    assign avail    = (pop_n_reg < count_reg) && (32'(pop_n_reg) < MAX_RESULTS);
    assign wakes    = avail && (rd_data.wake_time <= tick_reg);

    always_comb
    begin
        rd_idx = pop_n_reg;
        if ((state_reg == S_INS_RD) || (state_reg == S_INS_CMP))
        begin
            rd_idx = (slot_reg == '0) ? '0 : slot_reg - count_t'(1);
        end
    end

    assign rd_addr = phys(head_reg, rd_idx);

    swsq_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        tick_next        = tick_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        slot_next        = slot_reg;
        pop_n_next       = pop_n_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        resp_status_next = resp_status_reg;
        wake_next        = wake_reg;
        wr_en            = 1'b0;
        wr_addr          = phys(head_reg, slot_reg);
        wr_data          = rd_data;
        emit             = 1'b0;
        emit_data        = '0;
        emit_data.tick_now = tick_reg;
        emit_data.last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (item_reg.req_type == REQ_TICK)
                begin
                    tick_next       = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + tick_t'(1);
                    pop_n_next      = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_POP_RD;
                end
                else if (!positive)
                begin
                    resp_status_next = ST_IGNORED;
                    state_next       = S_RESP;
                end
                else if (32'(count_reg) >= QUEUE_DEPTH)
                begin
                    resp_status_next = ST_FULL;
                    state_next       = S_RESP;
                end
                else
                begin
                    wake_next  = wake_sum[TICK_BITS] ? TICK_MAX : wake_sum[TICK_BITS-1:0];
                    slot_next  = count_reg;
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                state_next = (slot_reg == '0) ? S_INS_PLACE : S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (rd_data.wake_time > wake_reg)
                begin
                    wr_en      = 1'b1;
                    slot_next  = slot_reg - count_t'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_PLACE;
                end
            end
            S_INS_PLACE:
            begin
                wr_en                = 1'b1;
                wr_data.wake_time    = wake_reg;
                wr_data.sleeper_id   = id_t'(item_reg.thread_id);
                count_next           = count_reg + count_t'(1);
                resp_status_next     = ST_QUEUED;
                state_next           = S_RESP;
            end
            S_POP_RD:
            begin
                state_next = S_POP_CMP;
            end
            S_POP_CMP:
            begin
                if (wakes)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        emit               = pend_valid_reg;
                        emit_data.status   = ST_WOKEN;
                        emit_data.woken_id = 8'(pend_id_reg);
                        emit_data.last     = 1'b0;
                        pend_id_next       = rd_data.sleeper_id;
                        pend_valid_next    = 1'b1;
                        pop_n_next         = pop_n_reg + count_t'(1);
                        state_next         = S_POP_RD;
                    end
                end
                else if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        emit               = 1'b1;
                        emit_data.status   = ST_WOKEN;
                        emit_data.woken_id = 8'(pend_id_reg);
                        head_next          = phys(head_reg, pop_n_reg);
                        count_next         = count_reg - pop_n_reg;
                        pend_valid_next    = 1'b0;
                        state_next         = S_IDLE;
                    end
                end
                else
                begin
                    resp_status_next = ST_NONE;
                    state_next       = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    emit_data.status = resp_status_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = emit_data;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg        <= slot_next;
        pop_n_reg       <= pop_n_next;
        pend_id_reg     <= pend_id_next;
        resp_status_reg <= resp_status_next;
        wake_reg        <= wake_next;
        rsp_reg         <= rsp_next;
        if (accept)
        begin
            item_reg <= req;
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= QUEUE_DEPTH)
        else $error("Queue count exceeds the queue depth.");

    a_only_woken_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_WOKEN)) |-> rsp.last)
        else $error("A single result transfer is not marked last.");

    a_write_only_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_INS_CMP) || (state_reg == S_INS_PLACE)))
        else $error("Queue memory written outside an insertion.");

    a_tick_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (tick_reg >= $past(tick_reg)))
        else $error("Tick counter moved backward.");

    a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> req_stall)
        else $error("Request taken while the previous one is still in work.");

endmodule

`default_nettype wire
